// ===== rtl/core/nfud_pkg.sv =====
// ----------------------------------------------------------------------------
// nfud_pkg: nearest free unit dispatch shared definitions
// Payload structs, opcodes, status codes, control types and the state enum.
// ----------------------------------------------------------------------------
package nfud_pkg;

  localparam int DIST_BITS = 33;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam logic [DIST_BITS-1:0] MAX_PICKUP_RESET = 33'd100;

  localparam logic [2:0] OP_ADD_REQ   = 3'd0;
  localparam logic [2:0] OP_ADD_UNIT  = 3'd1;
  localparam logic [2:0] OP_MOVE_UNIT = 3'd2;
  localparam logic [2:0] OP_SET_FREE  = 3'd3;
  localparam logic [2:0] OP_DISPATCH  = 3'd4;
  localparam logic [2:0] OP_END_JOB   = 3'd5;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_EXISTS    = 3'd1;
  localparam logic [2:0] STS_NO_UNIT   = 3'd2;
  localparam logic [2:0] STS_NO_REQ    = 3'd3;
  localparam logic [2:0] STS_NONE_NEAR = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         requester_slot;
    logic [3:0]         unit_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               free_flag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [3:0]           chosen_unit;
    logic [DIST_BITS-1:0] chosen_dist_sq;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic set_valid;
    logic set_pos;
    logic set_free;
    logic free_val;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/nfud_cell.sv =====
// ----------------------------------------------------------------------------
// nfud_cell: one unit slot of the rotating slot ring
// Holds valid, free and position; takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module nfud_cell import nfud_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic                  sel,
  input  logic [COORD_BITS-1:0] wx,
  input  logic [COORD_BITS-1:0] wy,
  input  logic                  nb_valid,
  input  logic                  nb_free,
  input  logic [COORD_BITS-1:0] nb_x,
  input  logic [COORD_BITS-1:0] nb_y,
  output logic                  valid,
  output logic                  free,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      free  <= 1'b0;
    end else if (cmd.shift) begin
      valid <= nb_valid;
      free  <= nb_free;
    end else if (sel) begin
      if (cmd.set_valid) begin
        valid <= 1'b1;
      end
      if (cmd.set_free) begin
        free <= cmd.free_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      x <= nb_x;
      y <= nb_y;
    end else if (sel && cmd.set_pos) begin
      x <= wx;
      y <= wy;
    end
  end

endmodule

// ===== rtl/core/nfud_dist.sv =====
// ----------------------------------------------------------------------------
// nfud_dist: shared squared distance and best candidate unit
// Three stages: absolute difference, square, sum with range and best compare.
// ----------------------------------------------------------------------------
module nfud_dist import nfud_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int SLOT_BITS  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  feed,
  input  logic                  elig,
  input  logic [SLOT_BITS-1:0]  slot,
  input  logic [COORD_BITS-1:0] ux,
  input  logic [COORD_BITS-1:0] uy,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [DIST_BITS-1:0]  max_sq,
  output logic                  busy,
  output logic                  found,
  output logic [SLOT_BITS-1:0]  best_slot,
  output logic [DIST_BITS-1:0]  best_dist
);

  localparam int SQ_BITS  = 2 * COORD_BITS;
  localparam int SUM_BITS = SQ_BITS + 1;
  localparam int CMP_BITS = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

  logic [COORD_BITS:0]   dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] mx, my;
  logic                  a_v, a_elig;
  logic [SLOT_BITS-1:0]  a_slot;
  logic [COORD_BITS-1:0] a_mx, a_my;
  logic                  b_v, b_elig;
  logic [SLOT_BITS-1:0]  b_slot;
  logic [SQ_BITS-1:0]    b_sx, b_sy;
  logic [SUM_BITS-1:0]   sum, best;
  logic [CMP_BITS-1:0]   sum_w, best_w;
  logic                  take;

  assign dx  = {ux[COORD_BITS-1], ux} - {px[COORD_BITS-1], px};
  assign dy  = {uy[COORD_BITS-1], uy} - {py[COORD_BITS-1], py};
  assign ndx = '0 - dx;
  assign ndy = '0 - dy;
  assign mx  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign my  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

  assign sum   = SUM_BITS'(b_sx) + SUM_BITS'(b_sy);
  assign sum_w = CMP_BITS'(sum);
  assign take  = b_v && b_elig && (sum_w <= CMP_BITS'(max_sq)) && (!found || sum < best);

  assign busy   = a_v || b_v;
  assign best_w = CMP_BITS'(best);
  assign best_dist = (best_w > CMP_BITS'(DIST_MAX)) ? DIST_MAX : best_w[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      found <= 1'b0;
    end else begin
      a_v <= feed;
      b_v <= a_v;
      if (start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_elig <= elig;
    a_slot <= slot;
    a_mx   <= mx;
    a_my   <= my;
    b_elig <= a_elig;
    b_slot <= a_slot;
    b_sx   <= SQ_BITS'(a_mx) * SQ_BITS'(a_mx);
    b_sy   <= SQ_BITS'(a_my) * SQ_BITS'(a_my);
    if (take) begin
      best      <= sum;
      best_slot <= b_slot;
    end
  end

endmodule

// ===== rtl/core/nearest_free_unit_dispatch_top.sv =====
// ----------------------------------------------------------------------------
// nearest_free_unit_dispatch_top: unit and requester table with dispatch
// Ring of unit cells rotating past one shared distance unit for dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid, in_stall, in_data): one operation per transaction.
//   out channel (out_valid, out_stall, out_data): one result per operation.
//   cfg channel (cfg_valid, cfg_ready, cfg_data): writes max_pickup_sq; write
//   it only while no operation is outstanding. cfg_ready is always high.
// Operation flow:
//   Table operations pass from S_IDLE to S_FINISH; in_stall holds off the
//   next operation until the result has moved into the output register.
//   Dispatch rotates the UNIT_SLOTS cells once past the distance unit, one
//   slot per cycle, then drains its 3-stage pipe and picks the nearest unit;
//   the rotation of the ring past the shared distance unit sets its duration.
// Reset: all units and requesters invalid, max_pickup_sq = 100.
// Stall: a result waits in the output register; the next operation is still
//   taken and its result waits internally until the output frees.
// ----------------------------------------------------------------------------
module nearest_free_unit_dispatch_top import nfud_pkg::*; #(
  parameter int UNIT_SLOTS      = 16,
  parameter int REQUESTER_SLOTS = 16,
  parameter int COORD_BITS      = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DIST_BITS-1:0] cfg_data
);

  localparam int SW = (UNIT_SLOTS > 1) ? $clog2(UNIT_SLOTS) : 1;
  localparam int RW = (REQUESTER_SLOTS > 1) ? $clog2(REQUESTER_SLOTS) : 1;

  state_t state, state_next;

  logic [DIST_BITS-1:0]       max_pickup_sq;
  logic [REQUESTER_SLOTS-1:0] req_valid;
  logic [SW-1:0]              cnt;
  logic [COORD_BITS-1:0]      pick_x, pick_y;
  logic [2:0]                 res_status, res_status_next;
  logic [3:0]                 res_unit, res_unit_next;
  logic [DIST_BITS-1:0]       res_dist, res_dist_next;
  logic                       res_load;
  logic                       req_set;
  logic                       accept, out_free, cnt_last;

  logic [31:0]           in_px_w, in_py_w;
  logic [COORD_BITS-1:0] in_px, in_py;
  logic [SW-1:0]         uidx, sel_idx;
  logic [RW-1:0]         ridx;
  logic                  unit_ok, req_ok, unit_hit, req_hit;

  cell_cmd_t             cmd;
  logic [UNIT_SLOTS-1:0] unit_valid, unit_free, cell_sel;
  logic [COORD_BITS-1:0] cell_x [UNIT_SLOTS];
  logic [COORD_BITS-1:0] cell_y [UNIT_SLOTS];

  logic                 dist_busy, dist_found, dist_start;
  logic [SW-1:0]        best_slot;
  logic [DIST_BITS-1:0] best_dist;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cnt_last  = (cnt == SW'(UNIT_SLOTS - 1));

  assign in_px_w = {16'b0, in_data.pos_x};
  assign in_py_w = {16'b0, in_data.pos_y};
  assign in_px   = in_px_w[COORD_BITS-1:0];
  assign in_py   = in_py_w[COORD_BITS-1:0];

  assign uidx     = SW'(in_data.unit_slot);
  assign ridx     = RW'(in_data.requester_slot);
  assign unit_ok  = int'(in_data.unit_slot) < UNIT_SLOTS;
  assign req_ok   = int'(in_data.requester_slot) < REQUESTER_SLOTS;
  assign unit_hit = unit_ok && unit_valid[uidx];
  assign req_hit  = req_ok && req_valid[ridx];

  assign sel_idx    = (state == S_PICK) ? best_slot : uidx;
  assign dist_start = accept && (in_data.opcode == OP_DISPATCH);

  for (genvar i = 0; i < UNIT_SLOTS; i++) begin : g_cell
    localparam int NB = (i + 1) % UNIT_SLOTS;
    assign cell_sel[i] = (sel_idx == SW'(i));
    nfud_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (cell_sel[i]),
      .wx       (in_px),
      .wy       (in_py),
      .nb_valid (unit_valid[NB]),
      .nb_free  (unit_free[NB]),
      .nb_x     (cell_x[NB]),
      .nb_y     (cell_y[NB]),
      .valid    (unit_valid[i]),
      .free     (unit_free[i]),
      .x        (cell_x[i]),
      .y        (cell_y[i])
    );
  end

  nfud_dist #(.COORD_BITS(COORD_BITS), .SLOT_BITS(SW)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .start     (dist_start),
    .feed      (state == S_SCAN),
    .elig      (unit_valid[0] && unit_free[0]),
    .slot      (cnt),
    .ux        (cell_x[0]),
    .uy        (cell_y[0]),
    .px        (pick_x),
    .py        (pick_y),
    .max_sq    (max_pickup_sq),
    .busy      (dist_busy),
    .found     (dist_found),
    .best_slot (best_slot),
    .best_dist (best_dist)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_data.opcode == OP_DISPATCH && req_hit) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!dist_busy) begin
          state_next = S_PICK;
        end
      end
      S_PICK: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    req_set         = 1'b0;
    res_load        = 1'b0;
    res_status_next = STS_OK;
    res_unit_next   = '0;
    res_dist_next   = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (in_data.opcode)
            OP_ADD_REQ: begin
              if (!req_ok) begin
                res_status_next = STS_NO_REQ;
              end else if (req_hit) begin
                res_status_next = STS_EXISTS;
              end else begin
                req_set = 1'b1;
              end
            end
            OP_ADD_UNIT: begin
              if (!unit_ok) begin
                res_status_next = STS_NO_UNIT;
              end else if (unit_hit) begin
                res_status_next = STS_EXISTS;
              end else begin
                cmd.set_valid = 1'b1;
                cmd.set_free  = 1'b1;
                cmd.free_val  = 1'b1;
                cmd.set_pos   = 1'b1;
              end
            end
            OP_MOVE_UNIT: begin
              if (!unit_hit) begin
                res_status_next = STS_NO_UNIT;
              end else begin
                cmd.set_pos = 1'b1;
              end
            end
            OP_SET_FREE: begin
              if (!unit_hit) begin
                res_status_next = STS_NO_UNIT;
              end else begin
                cmd.set_free = 1'b1;
                cmd.free_val = in_data.free_flag;
              end
            end
            OP_END_JOB: begin
              if (!unit_hit) begin
                res_status_next = STS_NO_UNIT;
              end else begin
                cmd.set_free = 1'b1;
                cmd.free_val = 1'b1;
              end
            end
            OP_DISPATCH: begin
              res_load        = !req_hit;
              res_status_next = STS_NO_REQ;
            end
            default: res_status_next = STS_OK;
          endcase
        end
      end
      S_SCAN: cmd.shift = 1'b1;
      S_PICK: begin
        res_load = 1'b1;
        if (dist_found) begin
          cmd.set_free  = 1'b1;
          cmd.free_val  = 1'b0;
          res_unit_next = 4'(best_slot);
          res_dist_next = best_dist;
        end else begin
          res_status_next = STS_NONE_NEAR;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_pickup_sq <= MAX_PICKUP_RESET;
      req_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_pickup_sq <= cfg_data;
      end
      if (req_set) begin
        req_valid[ridx] <= 1'b1;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt    <= '0;
      pick_x <= in_px;
      pick_y <= in_py;
    end else if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_unit   <= res_unit_next;
      res_dist   <= res_dist_next;
    end
    if (state == S_FINISH && out_free) begin
      out_data <= '{status: res_status, chosen_unit: res_unit, chosen_dist_sq: res_dist};
    end
  end

`ifndef SYNTHESIS
  a_pick_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> !dist_busy)
    else $error("pick taken while distance pipe still busy");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK && dist_found |-> best_dist <= max_pickup_sq)
    else $error("picked unit beyond pickup limit");

  a_pick_marks_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK && dist_found |=> !unit_free[$past(best_slot)])
    else $error("picked unit still marked free");

  a_scan_ring_home: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && cnt_last |=> state == S_DRAIN && cnt == '0)
    else $error("ring not back in place after full rotation");
`endif

endmodule
